// File: hw/rtl/srn_pkg.sv
package srn_pkg;

    // Request commands.
    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_SEED     = 2'd1,
        CMD_NEIGHBOR = 2'd2,
        CMD_ROW_END  = 2'd3
    } cmd_t;

    // Kinds of result.
    typedef enum logic [1:0] {
        KIND_SEED     = 2'd0,
        KIND_NEIGHBOR = 2'd1,
        KIND_ROW_END  = 2'd2
    } kind_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH0,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_PROBE,
        S_FINISH
    } state_t;

    // Outcome of a probe sequence.
    typedef enum logic [1:0] {
        PROBE_HIT,
        PROBE_FREE,
        PROBE_NONE
    } probe_t;

    // Multiplicative hash constant, split into 32-bit halves.
    localparam logic [31:0] GOLD_LO = 32'h7F4A_7C15;
    localparam logic [31:0] GOLD_HI = 32'h9E37_79B9;

    // Word widths of the hash datapath.
    localparam int HALF_W    = 32;
    localparam int KEY_EXT_W = 64;

    // Kept edge counter.
    localparam int ROW_W = 24;
    localparam logic [ROW_W-1:0] KEPT_MAX = 24'hFF_FFFF;

endpackage

// File: hw/rtl/srn_if.sv
// Request channel: one command with its node id and edge value.
interface srn_req_if #(
    parameter int NODE_ID_BITS = 32,
    parameter int VALUE_BITS   = 32
);
    logic                    valid;
    logic                    ready;
    srn_pkg::cmd_t           cmd;
    logic [NODE_ID_BITS-1:0] node_id;
    logic [VALUE_BITS-1:0]   edge_value;

    modport source (output valid, output cmd, output node_id, output edge_value,
                    input ready);
    modport sink   (input valid, input cmd, input node_id, input edge_value,
                    output ready);
endinterface

// Response channel: one relabelling result.
interface srn_rsp_if #(
    parameter int NODE_ID_BITS = 32,
    parameter int VALUE_BITS   = 32,
    parameter int LID_W        = 12
);
    logic                    valid;
    logic                    ready;
    srn_pkg::kind_t          kind;
    logic [LID_W-1:0]        local_id;
    logic [NODE_ID_BITS-1:0] new_node_id;
    logic [VALUE_BITS-1:0]   value_out;
    logic                    kept;
    logic                    is_new;
    logic [23:0]             row_offset;
    logic                    table_full;

    modport source (output valid, output kind, output local_id, output new_node_id,
                    output value_out, output kept, output is_new, output row_offset,
                    output table_full, input ready);
    modport sink   (input valid, input kind, input local_id, input new_node_id,
                    input value_out, input kept, input is_new, input row_offset,
                    input table_full, output ready);
endinterface

// Configuration write channel for the drop mode register.
interface srn_cfg_if;
    logic valid;
    logic ready;
    logic drop_unknown;

    modport source (output valid, output drop_unknown, input ready);
    modport sink   (input valid, input drop_unknown, output ready);
endinterface

// File: hw/rtl/subgraph_node_relabeler.sv
// Subgraph node relabeller.
// Requests arrive on req (cmd, node_id, edge_value) and results leave on rsp;
// both use a valid/ready handshake. cfg writes the drop_unknown register and
// is always ready; write it only while the block is idle.
// A seed or neighbour request runs a multiplicative hash on one shared
// 32x32 multiplier (three products), then probes the slot memory
// linearly, one slot per cycle, through its single read port, examining
// at least one slot. The result is then written to the output register,
// and only after that can the next request be taken. A row-end request
// goes straight to that final step. A clear request sweeps the whole
// slot memory and returns no result.
// After reset the same sweep runs before the first request is taken.
// A finished result sits in an output register; if the receiver stalls, the
// next request is still accepted and worked on, and it waits only to deliver
// its own result until the register is free.
module subgraph_node_relabeler #(
    parameter int MAP_ENTRIES  = 4096,
    parameter int HASH_SLOTS   = 8192,
    parameter int NODE_ID_BITS = 32,
    parameter int VALUE_BITS   = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    srn_cfg_if.sink   cfg,
    srn_req_if.sink   req,
    srn_rsp_if.source rsp
);
    import srn_pkg::*;

    localparam int  LID_W      = $clog2(MAP_ENTRIES);
    localparam int  CNT_W      = $clog2(MAP_ENTRIES + 1);
    localparam int  SLOT_W     = $clog2(HASH_SLOTS);
    localparam int  MEM_W      = 1 + NODE_ID_BITS + LID_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HASH_SLOTS - 1);
    localparam logic [CNT_W-1:0]  ENT_LIMIT = CNT_W'(MAP_ENTRIES);

    // Slot memory: {valid, key, local id}.
    logic [MEM_W-1:0]  slot_mem [HASH_SLOTS];
    logic [MEM_W-1:0]  rd_data_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [MEM_W-1:0]  wr_data;

    state_t state_reg, state_next;

    // Captured request.
    cmd_t                    cmd_reg, cmd_next;
    logic [NODE_ID_BITS-1:0] key_reg, key_next;
    logic [VALUE_BITS-1:0]   value_reg, value_next;

    // Hash datapath.
    logic [HALF_W-1:0]      mul_a, mul_b;
    logic [KEY_EXT_W-1:0]   prod_reg, prod_next;
    logic [HALF_W-1:0]      acc_reg, acc_next;
    logic [HALF_W-1:0]      hash_value;
    logic [KEY_EXT_W-1:0]   key_ext;
    logic [SLOT_W-1:0]      home_slot;

    // Probe sequencer.
    logic [SLOT_W-1:0] probe_addr_reg, probe_addr_next;
    logic [SLOT_W-1:0] probe_cnt_reg, probe_cnt_next;
    logic [SLOT_W-1:0] probe_step;
    probe_t            probe_res_reg, probe_res_next;
    logic [LID_W-1:0]  hit_id_reg, hit_id_next;
    logic              slot_used;
    logic [NODE_ID_BITS-1:0] slot_key;
    logic [LID_W-1:0]  slot_id;

    // Clearing sweep.
    logic [SLOT_W-1:0] sweep_cnt_reg, sweep_cnt_next;

    // Counters and configuration.
    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic [CNT_W-1:0] seed_count_reg, seed_count_next;
    logic [ROW_W-1:0] kept_edges_reg, kept_edges_next;
    logic             drop_unknown_reg;

    // Output register.
    logic                    rsp_valid_reg, rsp_valid_next;
    kind_t                   rsp_kind_reg, rsp_kind_next;
    logic [LID_W-1:0]        rsp_lid_reg, rsp_lid_next;
    logic [NODE_ID_BITS-1:0] rsp_node_reg, rsp_node_next;
    logic [VALUE_BITS-1:0]   rsp_value_reg, rsp_value_next;
    logic                    rsp_kept_reg, rsp_kept_next;
    logic                    rsp_new_reg, rsp_new_next;
    logic [ROW_W-1:0]        rsp_row_reg, rsp_row_next;
    logic                    rsp_full_reg, rsp_full_next;

    logic req_fire;
    logic out_space;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_space = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.kind        = rsp_kind_reg;
    assign rsp.local_id    = rsp_lid_reg;
    assign rsp.new_node_id = rsp_node_reg;
    assign rsp.value_out   = rsp_value_reg;
    assign rsp.kept        = rsp_kept_reg;
    assign rsp.is_new      = rsp_new_reg;
    assign rsp.row_offset  = rsp_row_reg;
    assign rsp.table_full  = rsp_full_reg;

    // Fields of the slot just read.
    assign slot_used = rd_data_reg[MEM_W-1];
    assign slot_key  = rd_data_reg[MEM_W-2 -: NODE_ID_BITS];
    assign slot_id   = rd_data_reg[LID_W-1:0];

    // Hash helpers: key split, final sum, home slot, probe wrap.
    assign key_ext    = KEY_EXT_W'(key_reg);
    assign hash_value = acc_reg + prod_reg[HALF_W-1:0];
    assign probe_step = (probe_addr_reg == SLOT_LAST) ? '0 : probe_addr_reg + 1'b1;

    // The home slot is the low hash bits, folded once into the slot range.
    assign home_slot = (hash_value[SLOT_W-1:0] > SLOT_LAST)
                     ? hash_value[SLOT_W-1:0] - SLOT_W'(HASH_SLOTS)
                     : hash_value[SLOT_W-1:0];

    // Shared multiplier, registered.
    assign prod_next = KEY_EXT_W'(mul_a) * KEY_EXT_W'(mul_b);

    // Slot memory ports.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= slot_mem[rd_addr];
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_unknown_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            drop_unknown_reg <= cfg.drop_unknown;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            sweep_cnt_reg   <= '0;
            entry_count_reg <= '0;
            seed_count_reg  <= '0;
            kept_edges_reg  <= '0;
            rsp_valid_reg   <= 1'b0;
            probe_cnt_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            entry_count_reg <= entry_count_next;
            seed_count_reg  <= seed_count_next;
            kept_edges_reg  <= kept_edges_next;
            rsp_valid_reg   <= rsp_valid_next;
            probe_cnt_reg   <= probe_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        probe_addr_reg <= probe_addr_next;
        probe_res_reg  <= probe_res_next;
        hit_id_reg     <= hit_id_next;
        rsp_kind_reg   <= rsp_kind_next;
        rsp_lid_reg    <= rsp_lid_next;
        rsp_node_reg   <= rsp_node_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_kept_reg   <= rsp_kept_next;
        rsp_new_reg    <= rsp_new_next;
        rsp_row_reg    <= rsp_row_next;
        rsp_full_reg   <= rsp_full_next;
    end

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        value_next       = value_reg;
        acc_next         = acc_reg;
        probe_addr_next  = probe_addr_reg;
        probe_cnt_next   = probe_cnt_reg;
        probe_res_next   = probe_res_reg;
        hit_id_next      = hit_id_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        entry_count_next = entry_count_reg;
        seed_count_next  = seed_count_reg;
        kept_edges_next  = kept_edges_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_kind_next    = rsp_kind_reg;
        rsp_lid_next     = rsp_lid_reg;
        rsp_node_next    = rsp_node_reg;
        rsp_value_next   = rsp_value_reg;
        rsp_kept_next    = rsp_kept_reg;
        rsp_new_next     = rsp_new_reg;
        rsp_row_next     = rsp_row_reg;
        rsp_full_next    = rsp_full_reg;
        mul_a            = key_ext[HALF_W-1:0];
        mul_b            = GOLD_LO;
        rd_addr          = probe_addr_reg;
        wr_en            = 1'b0;
        wr_addr          = probe_addr_reg;
        wr_data          = {1'b1, key_reg, hit_id_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                // Invalidate one slot per cycle.
                wr_en          = 1'b1;
                wr_addr        = sweep_cnt_reg;
                wr_data        = '0;
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == SLOT_LAST)
                begin
                    sweep_cnt_next = '0;
                    state_next     = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next   = req.cmd;
                    key_next   = req.node_id;
                    value_next = req.edge_value;
                    unique case (req.cmd)
                        CMD_CLEAR:
                        begin
                            entry_count_next = '0;
                            seed_count_next  = '0;
                            kept_edges_next  = '0;
                            sweep_cnt_next   = '0;
                            state_next       = S_CLEAR;
                        end
                        CMD_SEED, CMD_NEIGHBOR:
                        begin
                            state_next = S_HASH0;
                        end
                        CMD_ROW_END:
                        begin
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Low 64 bits of key * constant, upper half only:
            // (kl*cl)[63:32] + (kl*ch)[31:0] + (kh*cl)[31:0].
            S_HASH0:
            begin
                mul_a      = key_ext[HALF_W-1:0];
                mul_b      = GOLD_LO;
                state_next = S_HASH1;
            end

            S_HASH1:
            begin
                mul_a      = key_ext[HALF_W-1:0];
                mul_b      = GOLD_HI;
                acc_next   = prod_reg[KEY_EXT_W-1:HALF_W];
                state_next = S_HASH2;
            end

            S_HASH2:
            begin
                mul_a      = key_ext[KEY_EXT_W-1:HALF_W];
                mul_b      = GOLD_LO;
                acc_next   = acc_reg + prod_reg[HALF_W-1:0];
                state_next = S_HASH3;
            end

            S_HASH3:
            begin
                // Start the first read at the home slot.
                probe_cnt_next  = '0;
                rd_addr         = home_slot;
                probe_addr_next = home_slot;
                state_next      = S_PROBE;
            end

            S_PROBE:
            begin
                // Examine one slot per cycle; read the next one if needed.
                if (!slot_used)
                begin
                    probe_res_next = PROBE_FREE;
                    state_next     = S_FINISH;
                end
                else if (slot_key == key_reg)
                begin
                    probe_res_next = PROBE_HIT;
                    hit_id_next    = slot_id;
                    state_next     = S_FINISH;
                end
                else if (probe_cnt_reg == SLOT_LAST)
                begin
                    probe_res_next = PROBE_NONE;
                    state_next     = S_FINISH;
                end
                else
                begin
                    probe_cnt_next  = probe_cnt_reg + 1'b1;
                    rd_addr         = probe_step;
                    probe_addr_next = probe_step;
                end
            end

            S_FINISH:
            begin
                // Commit the result once the output register is free.
                if (out_space)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_lid_next   = '0;
                    rsp_node_next  = key_reg;
                    rsp_value_next = '0;
                    rsp_kept_next  = 1'b0;
                    rsp_new_next   = 1'b0;
                    rsp_row_next   = '0;
                    rsp_full_next  = 1'b0;
                    priority case (cmd_reg)
                        CMD_SEED:
                        begin
                            rsp_kind_next = KIND_SEED;
                            if (probe_res_reg == PROBE_HIT)
                            begin
                                rsp_lid_next = hit_id_reg;
                            end
                            else if (probe_res_reg == PROBE_FREE
                                     && entry_count_reg < ENT_LIMIT
                                     && seed_count_reg < ENT_LIMIT)
                            begin
                                wr_en            = 1'b1;
                                wr_data          = {1'b1, key_reg, LID_W'(seed_count_reg)};
                                entry_count_next = entry_count_reg + 1'b1;
                                rsp_lid_next     = LID_W'(seed_count_reg);
                            end
                            else
                            begin
                                rsp_full_next = 1'b1;
                            end
                            if (seed_count_reg < ENT_LIMIT)
                            begin
                                seed_count_next = seed_count_reg + 1'b1;
                            end
                        end
                        CMD_NEIGHBOR:
                        begin
                            rsp_kind_next = KIND_NEIGHBOR;
                            if (probe_res_reg == PROBE_HIT)
                            begin
                                rsp_lid_next   = hit_id_reg;
                                rsp_value_next = value_reg;
                                rsp_kept_next  = 1'b1;
                            end
                            else if (drop_unknown_reg)
                            begin
                                // Unknown neighbour dropped: nothing kept.
                                rsp_kept_next = 1'b0;
                            end
                            else if (probe_res_reg == PROBE_FREE
                                     && entry_count_reg < ENT_LIMIT)
                            begin
                                wr_en            = 1'b1;
                                wr_data          = {1'b1, key_reg, LID_W'(entry_count_reg)};
                                entry_count_next = entry_count_reg + 1'b1;
                                rsp_lid_next     = LID_W'(entry_count_reg);
                                rsp_value_next   = value_reg;
                                rsp_kept_next    = 1'b1;
                                rsp_new_next     = 1'b1;
                            end
                            else
                            begin
                                rsp_full_next = 1'b1;
                            end
                            if (rsp_kept_next && kept_edges_reg != KEPT_MAX)
                            begin
                                kept_edges_next = kept_edges_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_kind_next = KIND_ROW_END;
                            rsp_node_next = '0;
                            rsp_row_next  = kept_edges_reg;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/srn_checker.sv
// Port-level checks for the subgraph node relabeller.
module srn_checker #(
    parameter int LID_W = 12
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input srn_pkg::cmd_t  req_cmd,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input srn_pkg::kind_t rsp_kind,
    input logic [LID_W-1:0] rsp_local_id,
    input logic           rsp_kept,
    input logic           rsp_is_new,
    input logic           rsp_table_full
);
    import srn_pkg::*;

    // A pending result is held until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn while stalled");

    // Requests are worked on one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // A clear request produces no result.
    a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_cmd == CMD_CLEAR && !rsp_valid |=> !rsp_valid)
        else $error("result after clear");

    // Row-end results carry only the offset.
    a_row_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_ROW_END |->
            !rsp_kept && !rsp_is_new && !rsp_table_full && rsp_local_id == '0)
        else $error("row-end result with neighbour fields");

    // A freshly numbered neighbour is kept and never flagged full.
    a_new_is_kept: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_new |-> rsp_kept && !rsp_table_full)
        else $error("new neighbour not kept");

endmodule

bind subgraph_node_relabeler srn_checker #(
    .LID_W ($clog2(MAP_ENTRIES))
) u_srn_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_cmd        (req.cmd),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_kind       (rsp.kind),
    .rsp_local_id   (rsp.local_id),
    .rsp_kept       (rsp.kept),
    .rsp_is_new     (rsp.is_new),
    .rsp_table_full (rsp.table_full)
);

// File: bench/subgraph_node_relabeler_tb.sv
`timescale 1ns / 100ps

module subgraph_node_relabeler_tb;

    import srn_pkg::*;

    localparam int MAP_ENTRIES  = 4096;
    localparam int HASH_SLOTS   = 8192;
    localparam int NODE_ID_BITS = 32;
    localparam int VALUE_BITS   = 32;
    localparam bit [63:0] HASH_GOLD = {GOLD_HI, GOLD_LO};

    // One relabelling result as the block should deliver it.
    typedef struct packed {
        kind_t       kind;
        logic [11:0] local_id;
        logic [31:0] new_node_id;
        logic [31:0] value_out;
        logic        kept;
        logic        is_new;
        logic [23:0] row_offset;
        logic        table_full;
    } relabel_result_t;

    // Mirror of the node map and its counters, with the results still owed.
    class node_map_tracker;
        bit [31:0]       slot_key [HASH_SLOTS];
        bit [11:0]       slot_lid [HASH_SLOTS];
        bit              slot_used [HASH_SLOTS];
        int unsigned     entries;
        int unsigned     seeds;
        bit [23:0]       kept_edges;
        bit              drop_unknown;
        relabel_result_t owed_results [$];
        int unsigned     fail_count;
        int unsigned     checked;
        int unsigned     n_seed, n_hit, n_new, n_dropped, n_full, n_row_end, n_clear;

        function new();
            clear_map();
            drop_unknown = 1'b0;
        endfunction

        function void clear_map();
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            entries    = 0;
            seeds      = 0;
            kept_edges = '0;
        endfunction

        function int unsigned home_slot(bit [31:0] key);
            bit [63:0] prod;
            prod = 64'(key) * HASH_GOLD;
            return int'(prod[63:32] % HASH_SLOTS);
        endfunction

        // Linear probe from the home slot: a hit, the first free slot, or nothing.
        function probe_t probe(bit [31:0] key, output int unsigned pos);
            int unsigned h;
            h = home_slot(key);
            for (int unsigned n = 0; n < HASH_SLOTS; n++)
            begin
                if (!slot_used[h])
                begin
                    pos = h;
                    return PROBE_FREE;
                end
                if (slot_key[h] == key)
                begin
                    pos = h;
                    return PROBE_HIT;
                end
                h = (h + 1) % HASH_SLOTS;
            end
            pos = 0;
            return PROBE_NONE;
        endfunction

        function void store(int unsigned pos, bit [31:0] key, int unsigned lid);
            slot_used[pos] = 1'b1;
            slot_key[pos]  = key;
            slot_lid[pos]  = 12'(lid);
        endfunction

        function void note_config(bit mode);
            drop_unknown = mode;
        endfunction

        // Works out the result of an accepted request and queues it.
        function void note_request(cmd_t c, bit [31:0] id, bit [31:0] ev);
            relabel_result_t r;
            probe_t          p;
            int unsigned     pos;
            r = '0;
            if (c == CMD_CLEAR)
            begin
                clear_map();
                n_clear++;
                return;
            end
            case (c)
                CMD_SEED:
                begin
                    r.kind        = KIND_SEED;
                    r.new_node_id = id;
                    p = probe(id, pos);
                    if (p == PROBE_HIT)
                        r.local_id = slot_lid[pos];
                    else if (p == PROBE_FREE && entries < MAP_ENTRIES && seeds < MAP_ENTRIES)
                    begin
                        store(pos, id, seeds);
                        entries++;
                        r.local_id = 12'(seeds);
                    end
                    else
                    begin
                        r.table_full = 1'b1;
                        n_full++;
                    end
                    if (seeds < MAP_ENTRIES)
                        seeds++;
                    n_seed++;
                end
                CMD_NEIGHBOR:
                begin
                    r.kind        = KIND_NEIGHBOR;
                    r.new_node_id = id;
                    p = probe(id, pos);
                    if (p == PROBE_HIT)
                    begin
                        r.local_id  = slot_lid[pos];
                        r.value_out = ev;
                        r.kept      = 1'b1;
                        n_hit++;
                    end
                    else if (drop_unknown)
                        n_dropped++;
                    else if (p == PROBE_FREE && entries < MAP_ENTRIES)
                    begin
                        store(pos, id, entries);
                        r.local_id  = 12'(entries);
                        entries++;
                        r.value_out = ev;
                        r.kept      = 1'b1;
                        r.is_new    = 1'b1;
                        n_new++;
                    end
                    else
                    begin
                        r.table_full = 1'b1;
                        n_full++;
                    end
                    if (r.kept && kept_edges != KEPT_MAX)
                        kept_edges++;
                end
                default:
                begin
                    r.kind       = KIND_ROW_END;
                    r.row_offset = kept_edges;
                    n_row_end++;
                end
            endcase
            owed_results = {owed_results, r};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                fail_count++;
            end
        endfunction

        // Compares a delivered result with the oldest one owed.
        function void check_result(relabel_result_t got);
            relabel_result_t want;
            if (owed_results.size() == 0)
            begin
                $error("kind: expected no result, got 0x%0h", got.kind);
                fail_count++;
                return;
            end
            want = owed_results.pop_front();
            checked++;
            compare_field("kind", want.kind, got.kind);
            compare_field("local_id", want.local_id, got.local_id);
            compare_field("new_node_id", want.new_node_id, got.new_node_id);
            compare_field("value_out", want.value_out, got.value_out);
            compare_field("kept", want.kept, got.kept);
            compare_field("is_new", want.is_new, got.is_new);
            compare_field("row_offset", want.row_offset, got.row_offset);
            compare_field("table_full", want.table_full, got.table_full);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    srn_req_if #(.NODE_ID_BITS(NODE_ID_BITS), .VALUE_BITS(VALUE_BITS)) req_bus ();
    srn_rsp_if #(.NODE_ID_BITS(NODE_ID_BITS), .VALUE_BITS(VALUE_BITS)) rsp_bus ();
    srn_cfg_if cfg_bus ();

    subgraph_node_relabeler #(
        .MAP_ENTRIES  (MAP_ENTRIES),
        .HASH_SLOTS   (HASH_SLOTS),
        .NODE_ID_BITS (NODE_ID_BITS),
        .VALUE_BITS   (VALUE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    node_map_tracker relabel_map = new();

    bit          steady_flow;
    bit          clear_in_flight;
    int unsigned sent_count;
    bit [31:0]   recent_ids [$];

    // Clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result receiver, stalling now and then unless the flow is held steady.
    initial
    begin : result_sink
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_bus.ready <= steady_flow || ($urandom_range(99) >= 15);
        end
    end

    // Watches all three channels at each clock edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
                relabel_map.check_result('{rsp_bus.kind, rsp_bus.local_id,
                                           rsp_bus.new_node_id, rsp_bus.value_out,
                                           rsp_bus.kept, rsp_bus.is_new,
                                           rsp_bus.row_offset, rsp_bus.table_full});
            if (req_bus.valid && req_bus.ready)
                relabel_map.note_request(req_bus.cmd, req_bus.node_id, req_bus.edge_value);
            if (cfg_bus.valid && cfg_bus.ready)
                relabel_map.note_config(cfg_bus.drop_unknown);
        end
    end

    // Safety net against a hung block.
    initial
    begin : watchdog
        #100_000_000;
        $display("subgraph_node_relabeler: mismatch");
        $finish;
    end

    // Presents one request and holds it until it is taken. Valid is left high.
    task automatic send_request(cmd_t c, bit [31:0] id, bit [31:0] ev);
        while (!steady_flow && $urandom_range(99) < 15)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.cmd        <= c;
        req_bus.node_id    <= id;
        req_bus.edge_value <= ev;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        if (c == CMD_CLEAR)
        begin
            recent_ids.delete();
            clear_in_flight = 1'b1;
        end
        else if (c != CMD_ROW_END)
        begin
            recent_ids = {recent_ids, id};
            if (recent_ids.size() > 64)
                void'(recent_ids.pop_front());
        end
        sent_count++;
    endtask

    // Stops sending and waits for every owed result; a clear also needs its sweep.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (relabel_map.owed_results.size() != 0)
            @(posedge clk);
        repeat (clear_in_flight ? HASH_SLOTS + 32 : 16)
            @(posedge clk);
        clear_in_flight = 1'b0;
    endtask

    task automatic write_drop_mode(bit mode);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.drop_unknown <= mode;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly ids already seen since the last clear, sometimes extremes or fresh ones.
    function automatic bit [31:0] pick_node();
        int unsigned roll;
        roll = $urandom_range(99);
        if (recent_ids.size() != 0 && roll < 55)
            return recent_ids[$urandom_range(recent_ids.size() - 1)];
        if (roll < 60)
            return 32'h0000_0000;
        if (roll < 65)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // A well-formed batch: a few seeds, then rows of neighbours each closed by a row end.
    task automatic random_batch();
        int unsigned n_seeds;
        int unsigned n_rows;
        int unsigned n_edges;
        n_seeds = $urandom_range(0, 5);
        repeat (n_seeds)
            send_request(CMD_SEED, pick_node(), $urandom);
        n_rows = $urandom_range(1, 4);
        repeat (n_rows)
        begin
            n_edges = $urandom_range(0, 6);
            repeat (n_edges)
                send_request(CMD_NEIGHBOR, pick_node(), $urandom);
            send_request(CMD_ROW_END, $urandom, $urandom);
        end
    endtask

    // Random traffic: mostly batches, with clears, stray requests and full pauses.
    task automatic random_phase(int unsigned budget);
        int unsigned target;
        int unsigned roll;
        target = sent_count + budget;
        while (sent_count < target)
        begin
            roll = $urandom_range(99);
            if (roll < 5)
                send_request(CMD_CLEAR, $urandom, $urandom);
            else if (roll < 20)
                send_request(cmd_t'($urandom_range(3)), $urandom, $urandom);
            else if (roll < 23)
                drain_results();
            else
                random_batch();
        end
    endtask

    initial
    begin : stimulus
        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.cmd          = CMD_CLEAR;
        req_bus.node_id      = '0;
        req_bus.edge_value   = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.drop_unknown = 1'b0;
        steady_flow          = 1'b0;
        clear_in_flight      = 1'b0;
        sent_count           = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        write_drop_mode(1'b0);

        // Seeds at the id extremes, a duplicate seed, neighbour hits and a fresh neighbour.
        send_request(CMD_SEED, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(CMD_SEED, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(CMD_SEED, 32'h0000_0000, 32'h5555_AAAA);
        send_request(CMD_NEIGHBOR, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(CMD_NEIGHBOR, 32'h1234_5678, 32'h0000_0000);
        send_request(CMD_NEIGHBOR, 32'h1234_5678, 32'hAAAA_5555);
        send_request(CMD_NEIGHBOR, 32'hFFFF_FFFF, 32'h5555_AAAA);
        send_request(CMD_ROW_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // After a clear a neighbour takes id 0 and a later seed reuses its batch position.
        send_request(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_NEIGHBOR, 32'hAAAA_5555, 32'h0F0F_F0F0);
        send_request(CMD_SEED, 32'h5555_AAAA, 32'h0000_0000);
        send_request(CMD_ROW_END, 32'h0000_0000, 32'h0000_0000);
        drain_results();

        // Drop mode: unknown neighbours are dropped, seeds still insert.
        write_drop_mode(1'b1);
        send_request(CMD_NEIGHBOR, 32'hDEAD_0001, 32'h1357_9BDF);
        send_request(CMD_NEIGHBOR, 32'hAAAA_5555, 32'h2468_ACE0);
        send_request(CMD_SEED, 32'h0BAD_CAFE, 32'h0000_0000);
        send_request(CMD_NEIGHBOR, 32'h0BAD_CAFE, 32'hFFFF_FFFF);
        send_request(CMD_ROW_END, 32'h0000_0000, 32'h0000_0000);
        drain_results();

        // Random traffic in both modes, the middle stretch with no idling on either side.
        write_drop_mode(1'b0);
        random_phase(180);
        drain_results();
        write_drop_mode(1'b1);
        steady_flow = 1'b1;
        random_phase(120);
        steady_flow = 1'b0;
        drain_results();
        write_drop_mode(1'b0);
        random_phase(150);
        drain_results();

        $display("Covered %0d seeds, %0d neighbour hits, %0d new neighbours, %0d dropped,",
                 relabel_map.n_seed, relabel_map.n_hit, relabel_map.n_new,
                 relabel_map.n_dropped);
        $display("%0d refused for a full map, %0d row ends, %0d clears; %0d results checked.",
                 relabel_map.n_full, relabel_map.n_row_end, relabel_map.n_clear,
                 relabel_map.checked);
        if (relabel_map.fail_count == 0 && relabel_map.owed_results.size() == 0)
            $display("subgraph_node_relabeler: match");
        else
            $display("subgraph_node_relabeler: mismatch");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/srn_pkg.sv
hw/rtl/srn_if.sv
hw/rtl/subgraph_node_relabeler.sv
hw/rtl/srn_checker.sv
bench/subgraph_node_relabeler_tb.sv
